/* src/lru_key_value_cache_macros.svh */
// assertion macros for the checker file of the lru key/value cache
// depends on nothing; included by bare file name
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// clocked assertion, switched off while the given reset is low
`define LRUKV_ASSERT_CLK(lbl, ck, rstn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
        else $error("lru key/value cache check failed");

// same, on the local clk and rst_n
`define LRUKV_ASSERT(lbl, prop) \
    `LRUKV_ASSERT_CLK(lbl, clk, rst_n, prop)

`endif

/* src/lrukv_pkg.sv */
// types and fixed constants of the lru key/value cache
// no dependencies; imported by every module of the block but lrukv_ram
package lrukv_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 31;
    localparam int CFG_W = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                    func;
        logic signed [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0]        store_value;
    } req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_t;

    // what the search sweep found
    typedef struct packed {
        logic found;
        logic lru_found;
        logic free_found;
    } scan_flags_t;

    // kind of rewrite done by the update sweep
    typedef struct packed {
        logic insert;
        logic put;
    } upd_ctl_t;

endpackage

/* src/lrukv_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lrukv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/lrukv_scan.sv */
// search sweep tracker: key match, least recent entry and first free slot
// depends on lrukv_pkg
module lrukv_scan
    import lrukv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    en,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] idx,
    input  logic                                    entry_valid,
    input  logic [KEY_W-1:0]                        entry_key,
    input  logic [VAL_W-1:0]                        entry_val,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] entry_rank,
    input  logic [KEY_W-1:0]                        key,
    output scan_flags_t                             flags,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] match_idx,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] match_rank,
    output logic [VAL_W-1:0]                        match_val,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] lru_idx,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    scan_flags_t      flags_reg, flags_next;
    logic [IW-1:0]    match_idx_reg, match_idx_next;
    logic [IW-1:0]    match_rank_reg, match_rank_next;
    logic [VAL_W-1:0] match_val_reg, match_val_next;
    logic [IW-1:0]    lru_idx_reg, lru_idx_next;
    logic [IW-1:0]    lru_rank_reg, lru_rank_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;

    always_comb
    begin
        flags_next      = flags_reg;
        match_idx_next  = match_idx_reg;
        match_rank_next = match_rank_reg;
        match_val_next  = match_val_reg;
        lru_idx_next    = lru_idx_reg;
        lru_rank_next   = lru_rank_reg;
        free_idx_next   = free_idx_reg;
        if (start)
        begin
            flags_next = '0;
        end
        else if (en)
        begin
            if (entry_valid)
            begin
                if (!flags_reg.found && entry_key == key)
                begin
                    flags_next.found = 1'b1;
                    match_idx_next   = idx;
                    match_rank_next  = entry_rank;
                    match_val_next   = entry_val;
                end
                // first entry with the largest rank is the least recent
                if (!flags_reg.lru_found || entry_rank > lru_rank_reg)
                begin
                    flags_next.lru_found = 1'b1;
                    lru_idx_next         = idx;
                    lru_rank_next        = entry_rank;
                end
            end
            else if (!flags_reg.free_found)
            begin
                flags_next.free_found = 1'b1;
                free_idx_next         = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg  <= match_idx_next;
        match_rank_reg <= match_rank_next;
        match_val_reg  <= match_val_next;
        lru_idx_reg    <= lru_idx_next;
        lru_rank_reg   <= lru_rank_next;
        free_idx_reg   <= free_idx_next;
    end

    assign flags      = flags_reg;
    assign match_idx  = match_idx_reg;
    assign match_rank = match_rank_reg;
    assign match_val  = match_val_reg;
    assign lru_idx    = lru_idx_reg;
    assign free_idx   = free_idx_reg;

endmodule

/* src/lrukv_upd.sv */
// per-entry rewrite of the update sweep: move to front, overwrite, insert
// depends on lrukv_pkg
module lrukv_upd
    import lrukv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                                    en,
    input  upd_ctl_t                                ctl,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] idx,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] tgt,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] ref_rank,
    input  logic                                    entry_valid,
    input  logic [KEY_W+VAL_W+(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_word,
    input  logic [KEY_W-1:0]                        key,
    input  logic [VAL_W-1:0]                        val,
    output logic                                    we,
    output logic [KEY_W+VAL_W+(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wdata
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WW = KEY_W + VAL_W + RW;

    logic [KEY_W-1:0] old_key;
    logic [VAL_W-1:0] old_val;
    logic [RW-1:0]    old_rank;

    assign old_key  = rd_word[WW-1 -: KEY_W];
    assign old_val  = rd_word[RW+VAL_W-1 -: VAL_W];
    assign old_rank = rd_word[RW-1:0];

    always_comb
    begin
        we    = 1'b0;
        wdata = rd_word;
        if (en)
        begin
            if (idx == tgt)
            begin
                we = 1'b1;
                if (ctl.insert)
                begin
                    wdata = {key, val, {RW{1'b0}}};
                end
                else
                begin
                    wdata = {old_key, (ctl.put ? val : old_val), {RW{1'b0}}};
                end
            end
            // entries more recent than the touched one age by one; all age on insert
            else if (entry_valid && (ctl.insert || old_rank < ref_rank))
            begin
                we    = 1'b1;
                wdata = {old_key, old_val, RW'(old_rank + RW'(1))};
            end
        end
    end

endmodule

/* src/lru_key_value_cache.sv */
// lru key/value cache top level: sequencer, valid marks, occupancy, beat registers
// depends on lrukv_pkg, lrukv_ram, lrukv_scan, lrukv_upd
//
//   channel | valid     | ready     | data
//   --------+-----------+-----------+-----------------------------------
//   request | req_valid | req_ready | req  (func, lookup_key, store_value)
//   result  | rsp_valid | rsp_ready | rsp  (hit, read_value)
//   config  | cfg_we    | -         | cfg_wdata (capacity_in_use)
//
// one request at a time; the entry memory is swept one entry a cycle through its read port
// get miss: search sweep and decide step, then back to idle
// get hit and put: search sweep, decide, read-modify-write sweep
// reset clears valid marks and occupancy at once, no clearing pass; capacity resets to 16
// the decide step waits while an earlier result beat is still untaken
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int WW   = KEY_W + VAL_W + RW;
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pend_reg, pend_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    req_t             req_reg, req_next;
    logic [CFG_W-1:0] cap_reg, cap_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;
    logic [IW-1:0]    tgt_reg, tgt_next;
    logic [RW-1:0]    ref_rank_reg, ref_rank_next;
    upd_ctl_t         uctl_reg, uctl_next;

    logic             scan_start;
    logic             scan_en;
    logic             upd_en;
    logic             sweep_done;
    logic [WW-1:0]    rd_word;
    logic             ram_we;
    logic [WW-1:0]    ram_wdata;
    logic             entry_valid;
    scan_flags_t      flags;
    logic [IW-1:0]    match_idx;
    logic [RW-1:0]    match_rank;
    logic [VAL_W-1:0] match_val;
    logic [IW-1:0]    lru_idx;
    logic [IW-1:0]    free_idx;
    logic [CMPW-1:0]  cap_ext;
    logic [CMPW-1:0]  eff_cap;
    logic             evict;
    logic [IW-1:0]    ins_idx;
    logic             get_hit;

    assign sweep_done  = (cnt_reg == CW'(ENTRIES));
    assign entry_valid = valid_reg[pidx_reg];
    assign scan_en     = pend_reg && (state_reg == ST_SEARCH);
    assign upd_en      = pend_reg && (state_reg == ST_UPDATE);

    // capacity zero acts as one, above the entry count it saturates
    assign cap_ext = CMPW'(cap_reg);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(ENTRIES))
        begin
            eff_cap = CMPW'(ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict   = (CMPW'(occ_reg) >= eff_cap) && (occ_reg != '0);
    // lowest free slot once the victim is gone
    assign ins_idx = (evict && (!flags.free_found || lru_idx < free_idx)) ? lru_idx : free_idx;
    assign get_hit = (req_reg.func == FUNC_GET) && flags.found;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = cnt_reg[IW-1:0];
        req_next       = req_reg;
        cap_next       = cap_reg;
        occ_next       = occ_reg;
        valid_next     = valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        tgt_next       = tgt_reg;
        ref_rank_next  = ref_rank_reg;
        uctl_next      = uctl_reg;
        scan_start     = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cfg_we)
        begin
            cap_next = cfg_wdata;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    cnt_next   = '0;
                    scan_start = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH, ST_UPDATE:
            begin
                if (!sweep_done)
                begin
                    pend_next = 1'b1;
                    cnt_next  = CW'(cnt_reg + CW'(1));
                end
                else
                begin
                    state_next = (state_reg == ST_SEARCH) ? ST_DECIDE : ST_IDLE;
                end
            end
            ST_DECIDE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = get_hit;
                    rsp_next.read_value = get_hit ? match_val : '0;
                    cnt_next            = '0;
                    if (flags.found)
                    begin
                        uctl_next.insert = 1'b0;
                        uctl_next.put    = (req_reg.func == FUNC_PUT);
                        tgt_next         = match_idx;
                        ref_rank_next    = match_rank;
                        state_next       = ST_UPDATE;
                    end
                    else if (req_reg.func == FUNC_PUT)
                    begin
                        if (evict)
                        begin
                            valid_next[lru_idx] = 1'b0;
                        end
                        valid_next[ins_idx] = 1'b1;
                        occ_next         = evict ? occ_reg : CW'(occ_reg + CW'(1));
                        uctl_next.insert = 1'b1;
                        uctl_next.put    = 1'b1;
                        tgt_next         = ins_idx;
                        ref_rank_next    = '0;
                        state_next       = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            cap_reg       <= CAP_RESET;
            occ_reg       <= '0;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            uctl_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            cap_reg       <= cap_next;
            occ_reg       <= occ_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
            uctl_reg      <= uctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg     <= pidx_next;
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        tgt_reg      <= tgt_next;
        ref_rank_reg <= ref_rank_next;
    end

    // key, value and rank of every entry in one word
    lrukv_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx_reg),
        .wdata (ram_wdata),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (rd_word)
    );

    lrukv_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .en          (scan_en),
        .idx         (pidx_reg),
        .entry_valid (entry_valid),
        .entry_key   (rd_word[WW-1 -: KEY_W]),
        .entry_val   (rd_word[RW+VAL_W-1 -: VAL_W]),
        .entry_rank  (rd_word[RW-1:0]),
        .key         (req_reg.lookup_key),
        .flags       (flags),
        .match_idx   (match_idx),
        .match_rank  (match_rank),
        .match_val   (match_val),
        .lru_idx     (lru_idx),
        .free_idx    (free_idx)
    );

    lrukv_upd #(
        .ENTRIES (ENTRIES)
    ) u_upd (
        .en          (upd_en),
        .ctl         (uctl_reg),
        .idx         (pidx_reg),
        .tgt         (tgt_reg),
        .ref_rank    (ref_rank_reg),
        .entry_valid (entry_valid),
        .rd_word     (rd_word),
        .key         (req_reg.lookup_key),
        .val         (req_reg.store_value),
        .we          (ram_we),
        .wdata       (ram_wdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* src/lrukv_chk.sv */
// port level checks of the lru key/value cache, bound to the top level
// depends on lrukv_pkg and lru_key_value_cache_macros.svh
`include "lru_key_value_cache_macros.svh"

module lrukv_chk
    import lrukv_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // one request in flight at a time
    `LRUKV_ASSERT(a_busy_after_accept, (req_valid && req_ready) |=> !req_ready)

    // a result never comes in the cycle after its request beat
    `LRUKV_ASSERT(a_no_instant_rsp, (req_valid && req_ready) |=> !$rose(rsp_valid))

    // a miss or a put always carries a zero value
    `LRUKV_ASSERT(a_miss_zero, (rsp_valid && !rsp.hit) |-> (rsp.read_value == '0))

    // an untaken result beat holds
    `LRUKV_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))

endmodule

bind lru_key_value_cache lrukv_chk u_chk (.*);

/* bench/tb_lru_key_value_cache.sv */
// self-checking bench for the lru key/value cache: directed table, then random get/put traffic
// depends on lrukv_pkg and lru_key_value_cache; expected results from the table or a cache model
module tb_lru_key_value_cache;
    import lrukv_pkg::*;

    localparam int ENTRIES = 16;
    localparam int SETTLE = 2 * ENTRIES + 8;
    localparam int POOL = 24;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 100;
    localparam logic [CFG_W-1:0] KEEP = 5'd0;
    localparam bit FIXED = 1'b1;
    localparam bit PREDICT = 1'b0;

    typedef struct {
        logic [CFG_W-1:0] cap;
        logic             func;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] data;
        bit               fixed;
        logic             hit;
        logic [VAL_W-1:0] rd;
    } plan_row_t;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_t             req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    // cache model state
    logic [KEY_W-1:0] kv_key [ENTRIES];
    logic [VAL_W-1:0] kv_val [ENTRIES];
    bit               kv_used [ENTRIES];
    int unsigned      kv_age [ENTRIES];
    int unsigned      kv_count = 0;
    logic [CFG_W-1:0] cap_reg = CAP_RESET;

    rsp_t             awaited_rsp [$];
    logic [KEY_W-1:0] key_pool [POOL];
    logic [KEY_W-1:0] corner_keys [4] = '{32'h0000_0000, 32'hffff_ffff,
                                          32'h8000_0000, 32'h7fff_ffff};
    bit               no_idle = 1'b0;
    int unsigned      mismatches = 0;
    int unsigned      items_sent = 0;
    int unsigned      get_hits = 0;
    int unsigned      evictions = 0;
    int unsigned      cap_settings = 0;

    plan_row_t directed_plan [22] = '{
        // empty after reset
        '{KEEP, FUNC_GET, 32'h0000_0000, 31'h0000_0000, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h8000_0000, 31'h7fff_ffff, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_PUT, 32'h8000_0000, 31'h7fff_ffff, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h8000_0000, 31'h0000_0000, FIXED, 1'b1, 31'h7fff_ffff},
        '{KEEP, FUNC_PUT, 32'h7fff_ffff, 31'h0000_0000, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h7fff_ffff, 31'h7fff_ffff, FIXED, 1'b1, 31'h0},
        '{KEEP, FUNC_PUT, 32'hffff_ffff, 31'h5555_5555, FIXED, 1'b0, 31'h0},
        // overwrite of a present key
        '{KEEP, FUNC_PUT, 32'hffff_ffff, 31'h2aaa_aaaa, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'hffff_ffff, 31'h0000_0000, FIXED, 1'b1, 31'h2aaa_aaaa},
        '{KEEP, FUNC_GET, 32'h7fff_fffe, 31'h0000_0000, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_PUT, 32'h0000_0000, 31'h0000_0001, FIXED, 1'b0, 31'h0},
        // capacity dropped below occupancy: each new key swaps out the oldest
        '{5'd1,  FUNC_PUT, 32'h0000_0005, 31'h0000_0005, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h8000_0000, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h0000_0005, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h7fff_ffff, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{KEEP, FUNC_PUT, 32'h0000_0006, 31'h0000_0006, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'hffff_ffff, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h0000_0000, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{5'd16, FUNC_PUT, 32'h8000_0000, 31'h7fff_ffff, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h0000_0006, 31'h0000_0000, PREDICT, 1'b0, 31'h0},
        '{5'd2,  FUNC_PUT, 32'h1234_5678, 31'h0765_4321, FIXED, 1'b0, 31'h0},
        '{KEEP, FUNC_GET, 32'h8000_0000, 31'h0000_0000, PREDICT, 1'b0, 31'h0}
    };

    lru_key_value_cache #(
        .ENTRIES(ENTRIES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("tb_lru_key_value_cache NOT OK");
        $finish;
    end

    // make entry idx the newest; everything newer than it ages by one
    function automatic void promote(int idx);
        int unsigned r;
        r = kv_age[idx];
        for (int i = 0; i < ENTRIES; i++)
            if (kv_used[i] && i != idx && kv_age[i] < r)
                kv_age[i]++;
        kv_age[idx] = 0;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t        res;
        int          slot;
        int          victim;
        int unsigned limit;
        res = '0;
        slot = -1;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && kv_used[i] && kv_key[i] == r.lookup_key)
                slot = i;
        if (r.func == FUNC_GET)
        begin
            if (slot >= 0)
            begin
                res.hit = 1'b1;
                res.read_value = kv_val[slot];
                promote(slot);
                get_hits++;
            end
            return res;
        end
        if (slot >= 0)
        begin
            kv_val[slot] = r.store_value;
            promote(slot);
            return res;
        end
        limit = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
        if (kv_count >= limit && kv_count > 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (kv_used[i] && (victim < 0 || kv_age[i] > kv_age[victim]))
                    victim = i;
            kv_used[victim] = 1'b0;
            kv_count--;
            evictions++;
        end
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!kv_used[i])
            begin
                for (int j = 0; j < ENTRIES; j++)
                    if (kv_used[j])
                        kv_age[j]++;
                kv_used[i] = 1'b1;
                kv_key[i] = r.lookup_key;
                kv_val[i] = r.store_value;
                kv_age[i] = 0;
                kv_count++;
                break;
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t on %s: got %h, want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_request(req_t r, bit use_fixed, rsp_t fixed_rsp);
        int unsigned gap;
        rsp_t        pred;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        pred = cache_access(r);
        awaited_rsp.push_back(use_fixed ? fixed_rsp : pred);
        items_sent++;
    endtask

    // capacity only changes once the cache has gone quiet
    task automatic set_capacity(logic [CFG_W-1:0] c);
        req_valid <= 1'b0;
        wait (awaited_rsp.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        cap_reg = c;
        cap_settings++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int unsigned cap);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            return key_pool[$urandom_range(0, cap + 3)];
        else if (sel < 90)
            return $urandom;
        return corner_keys[$urandom_range(0, 3)];
    endfunction

    // result side: random stall before each beat, then check against the oldest expectation
    initial
    begin : result_side
        int unsigned stall;
        rsp_t        want;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_valid);
            if (awaited_rsp.size() == 0)
                note_mismatch("result with nothing pending", rsp, 32'h0);
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp.hit !== want.hit)
                    note_mismatch("hit", 32'(rsp.hit), 32'(want.hit));
                if (rsp.read_value !== want.read_value)
                    note_mismatch("read_value", 32'(rsp.read_value), 32'(want.read_value));
            end
        end
    end

    initial
    begin : request_side
        req_t             r;
        rsp_t             fixed_rsp;
        logic [CFG_W-1:0] cap;
        int unsigned      sel;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            kv_used[i] = 1'b0;
            kv_age[i] = 0;
        end
        for (int i = 0; i < POOL; i++)
            key_pool[i] = $urandom;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].cap != KEEP)
                set_capacity(directed_plan[i].cap);
            r.func = directed_plan[i].func;
            r.lookup_key = directed_plan[i].key;
            r.store_value = directed_plan[i].data;
            fixed_rsp.hit = directed_plan[i].hit;
            fixed_rsp.read_value = directed_plan[i].rd;
            send_request(r, directed_plan[i].fixed, fixed_rsp);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                cap = 5'd1;
            else if (p == 1)
                cap = 5'd16;
            else
                cap = $urandom_range(1, 16);
            set_capacity(cap);
            no_idle = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // let the cache drain completely once in a while
                if (n == PHASE_ITEMS / 2 && p % 2 == 0)
                begin
                    req_valid <= 1'b0;
                    wait (awaited_rsp.size() == 0);
                    @(posedge clk);
                end
                r.func = ($urandom_range(0, 99) < 45) ? FUNC_PUT : FUNC_GET;
                r.lookup_key = pick_key(cap);
                sel = $urandom_range(0, 19);
                if (sel == 0)
                    r.store_value = '0;
                else if (sel == 1)
                    r.store_value = '1;
                else
                    r.store_value = $urandom;
                send_request(r, PREDICT, '0);
            end
        end
        no_idle = 1'b0;

        req_valid <= 1'b0;
        wait (awaited_rsp.size() == 0);
        repeat (SETTLE) @(posedge clk);
        $display("%0d requests checked: %0d get hits, %0d evictions", items_sent, get_hits,
                 evictions);
        $display("%0d capacity settings from 1 to 16, with and without stalls", cap_settings);
        if (mismatches == 0)
            $display("tb_lru_key_value_cache OK");
        else
            $display("tb_lru_key_value_cache NOT OK");
        $finish;
    end

endmodule
